// File: rtl/core/plle_pkg.sv
// Shared types, codes and helpers for the pooled linked list engine.
// No dependencies; plle_ctrl and the top level in rtl/core import this package.
`default_nettype none

package plle_pkg;

    // Node pool size; links are 11-bit signed, so at most 1024 nodes are addressable
    localparam int POOL_NODES = 1024;
    localparam int POOL_CAP   = (POOL_NODES < 1024) ? POOL_NODES : 1024;

    localparam int IDX_W      = $clog2(POOL_CAP);       // pool address width
    localparam int CNT_W      = $clog2(POOL_CAP + 1);   // holds 0 .. POOL_CAP
    localparam int LINK_W     = 11;
    localparam int VAL_W      = 64;
    localparam int NIDX_W     = 10;
    localparam int KIND_W     = 2;
    localparam int STAT_W     = 2;

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic signed [LINK_W-1:0] link_t;
    typedef logic [VAL_W-1:0]         val_t;
    typedef logic [KIND_W-1:0]        kind_t;
    typedef logic [STAT_W-1:0]        stat_t;

    // End-of-list / head marker
    localparam link_t LINK_NONE = {LINK_W{1'b1}};

    // Item kinds
    localparam kind_t KIND_BEGIN  = 2'd0;
    localparam kind_t KIND_LOAD   = 2'd1;
    localparam kind_t KIND_REMOVE = 2'd2;
    localparam kind_t KIND_INSERT = 2'd3;

    // Result status codes
    localparam stat_t ST_OK     = 2'd0;
    localparam stat_t ST_FULL   = 2'd1;
    localparam stat_t ST_NONODE = 2'd2;

    typedef struct packed {
        kind_t kind;
        link_t pos;
        val_t  payload;
        link_t link;
    } item_t;

    typedef struct packed {
        val_t              removed_value;
        logic [NIDX_W-1:0] new_index;
        stat_t             status;
    } res_t;

    // One-port-write / one-port-read request to a node RAM
    typedef struct packed {
        logic  we;
        idx_t  waddr;
        link_t wdata;
        idx_t  raddr;
    } lnk_req_t;

    typedef struct packed {
        logic  we;
        idx_t  waddr;
        val_t  wdata;
        idx_t  raddr;
    } val_req_t;

    // A link names an existing node when it is non-negative and below the used count
    function automatic logic is_node(link_t i, cnt_t cnt);
        is_node = !i[LINK_W-1] && (LINK_W'(i[NIDX_W-1:0]) < LINK_W'(cnt));
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/plle_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module plle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/plle_ctrl.sv
// Item sequencer: reads, modifies and writes back the node RAMs, keeps head and count.
// Depends on plle_pkg; drives the value and link RAMs instantiated in the top level.
`default_nettype none

module plle_ctrl
    import plle_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    // item transfer in
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire item_t    in_item,
    // result transfer out
    output logic          res_valid,
    input  wire logic     res_ready,
    output res_t          res,
    // node RAM access
    output lnk_req_t      lnk_req,
    input  wire link_t    lnk_rdata,
    output val_req_t      val_req,
    input  wire val_t     val_rdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_RD1  = 3'd2;
    localparam logic [2:0] S_RD2  = 3'd3;
    localparam logic [2:0] S_INS  = 3'd4;
    localparam logic [2:0] S_INS2 = 3'd5;
    localparam logic [2:0] S_RESP = 3'd6;

    logic [2:0] state_reg, state_next;
    item_t      item_reg, item_next;
    link_t      head_reg, head_next;
    cnt_t       cnt_reg, cnt_next;
    res_t       res_reg, res_next;

    logic pos_is_head, pos_ok, full;
    idx_t slot, pos_idx;

    assign pos_is_head = (item_reg.pos == LINK_NONE);
    assign pos_ok      = is_node(item_reg.pos, cnt_reg);
    assign full        = (cnt_reg == CNT_W'(POOL_CAP));
    assign slot        = cnt_reg[IDX_W-1:0];
    assign pos_idx     = item_reg.pos[IDX_W-1:0];

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res       = res_reg;

    // Sequencer. Only one item is in flight and no read is issued in the same
    // cycle as a write, so RAM accesses never overlap.
    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        head_next  = head_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        lnk_req    = '0;
        val_req    = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    item_next  = in_item;
                    state_next = S_DEC;
                end
            end

            S_DEC: begin
                case (item_reg.kind)
                    KIND_BEGIN: begin
                        head_next  = item_reg.pos;
                        cnt_next   = '0;
                        state_next = S_IDLE;
                    end
                    KIND_LOAD: begin
                        if (full) begin
                            res_next   = '{removed_value: '0, new_index: '0, status: ST_FULL};
                            state_next = S_RESP;
                        end else begin
                            lnk_req.we    = 1'b1;
                            lnk_req.waddr = slot;
                            lnk_req.wdata = item_reg.link;
                            val_req.we    = 1'b1;
                            val_req.waddr = slot;
                            val_req.wdata = item_reg.payload;
                            cnt_next      = cnt_reg + CNT_W'(1);
                            state_next    = S_IDLE;
                        end
                    end
                    KIND_REMOVE: begin
                        if (pos_is_head && is_node(head_reg, cnt_reg)) begin
                            // victim is the head node: fetch its link and value
                            lnk_req.raddr = head_reg[IDX_W-1:0];
                            val_req.raddr = head_reg[IDX_W-1:0];
                            state_next    = S_RD2;
                        end else if (!pos_is_head && pos_ok) begin
                            lnk_req.raddr = pos_idx;
                            state_next    = S_RD1;
                        end else begin
                            res_next   = '{removed_value: '0, new_index: '0, status: ST_NONODE};
                            state_next = S_RESP;
                        end
                    end
                    default: begin
                        // insert after
                        if (full) begin
                            res_next   = '{removed_value: '0, new_index: '0, status: ST_FULL};
                            state_next = S_RESP;
                        end else if (pos_is_head) begin
                            lnk_req.we    = 1'b1;
                            lnk_req.waddr = slot;
                            lnk_req.wdata = head_reg;
                            val_req.we    = 1'b1;
                            val_req.waddr = slot;
                            val_req.wdata = item_reg.payload;
                            head_next     = LINK_W'(slot);
                            cnt_next      = cnt_reg + CNT_W'(1);
                            res_next      = '{removed_value: '0, new_index: NIDX_W'(slot),
                                              status: ST_OK};
                            state_next    = S_RESP;
                        end else if (pos_ok) begin
                            lnk_req.raddr = pos_idx;
                            state_next    = S_INS;
                        end else begin
                            res_next   = '{removed_value: '0, new_index: '0, status: ST_NONODE};
                            state_next = S_RESP;
                        end
                    end
                endcase
            end

            // link of position arrived: it names the victim
            S_RD1: begin
                if (is_node(lnk_rdata, cnt_reg)) begin
                    lnk_req.raddr = lnk_rdata[IDX_W-1:0];
                    val_req.raddr = lnk_rdata[IDX_W-1:0];
                    state_next    = S_RD2;
                end else begin
                    res_next   = '{removed_value: '0, new_index: '0, status: ST_NONODE};
                    state_next = S_RESP;
                end
            end

            // victim link and value arrived: bypass the victim
            S_RD2: begin
                if (pos_is_head) begin
                    head_next = lnk_rdata;
                end else begin
                    lnk_req.we    = 1'b1;
                    lnk_req.waddr = pos_idx;
                    lnk_req.wdata = lnk_rdata;
                end
                res_next   = '{removed_value: val_rdata, new_index: '0, status: ST_OK};
                state_next = S_RESP;
            end

            // new node takes over the successor of position
            S_INS: begin
                lnk_req.we    = 1'b1;
                lnk_req.waddr = slot;
                lnk_req.wdata = lnk_rdata;
                val_req.we    = 1'b1;
                val_req.waddr = slot;
                val_req.wdata = item_reg.payload;
                state_next    = S_INS2;
            end

            // position now points at the new node
            S_INS2: begin
                lnk_req.we    = 1'b1;
                lnk_req.waddr = pos_idx;
                lnk_req.wdata = LINK_W'(slot);
                cnt_next      = cnt_reg + CNT_W'(1);
                res_next      = '{removed_value: '0, new_index: NIDX_W'(slot), status: ST_OK};
                state_next    = S_RESP;
            end

            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= LINK_NONE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
        end
    end

    // item and result payload
    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    // count never passes the pool size
    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(POOL_CAP))
        else $error("used count above pool size");

    // link writes only touch existing nodes or the next free slot
    a_lnk_waddr: assert property (@(posedge aclk) disable iff (!aresetn)
        lnk_req.we |-> (CNT_W'(lnk_req.waddr) <= cnt_reg))
        else $error("link write beyond used nodes");

    // one item at a time: no new transfer right after one is taken
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while busy");

    // a held result stays put until it is taken
    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid && $stable(res_reg))
        else $error("pending result changed");

endmodule

`default_nettype wire

// File: rtl/core/pooled_linked_list_engine.sv
// Pooled linked list engine: stream ports, node RAMs, sequencer and output register.
// Depends on plle_pkg, plle_ram and plle_ctrl.
//
// Keeps one singly linked list of 64-bit values in a pool of POOL_CAP nodes held in two
// synchronous RAMs (values and links), with a head link and a used-node count in
// registers. Items are processed one at a time. The link RAM has registered read data,
// so a remove after a node reads the position link and then the victim link in series,
// and it has a single write port, so an insert after a node writes the new node's link
// and then the position's link in separate states. Results that wait in the output
// register do not hold up the next item unless a second result is ready before the
// first is taken. Begin gives no result; a load gives one only when the pool is full
// (status 1). Remove and insert always give one: status 0 ok, 1 pool full, 2 no such
// node. No clearing pass is needed after reset: only nodes below the used count are
// ever read.
`default_nettype none

module pooled_linked_list_engine
    import plle_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,   // position[10:0], payload[74:11], link_in[85:75], zero
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // removed_value[63:0], new_index[73:64], zero
    output logic [1:0]       m_tuser    // status[1:0]
);

    item_t    in_item;
    res_t     res, m_res_reg;
    logic     res_valid, res_ready;
    logic     m_tvalid_reg;
    lnk_req_t lnk_req;
    val_req_t val_req;
    link_t    lnk_rdata;
    val_t     val_rdata;

    // unpack the input transfer
    assign in_item.kind    = s_tuser;
    assign in_item.pos     = s_tdata[10:0];
    assign in_item.payload = s_tdata[74:11];
    assign in_item.link    = s_tdata[85:75];

    plle_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .lnk_req   (lnk_req),
        .lnk_rdata (lnk_rdata),
        .val_req   (val_req),
        .val_rdata (val_rdata)
    );

    plle_ram #(.WIDTH(LINK_W), .DEPTH(POOL_CAP)) u_link_ram (
        .aclk  (aclk),
        .we    (lnk_req.we),
        .waddr (lnk_req.waddr),
        .wdata (lnk_req.wdata),
        .raddr (lnk_req.raddr),
        .rdata (lnk_rdata)
    );

    plle_ram #(.WIDTH(VAL_W), .DEPTH(POOL_CAP)) u_value_ram (
        .aclk  (aclk),
        .we    (val_req.we),
        .waddr (val_req.waddr),
        .wdata (val_req.wdata),
        .raddr (val_req.raddr),
        .rdata (val_rdata)
    );

    // output register: free when empty or being drained this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    // pack the result transfer
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_res_reg.new_index, m_res_reg.removed_value};
    assign m_tuser  = m_res_reg.status;

endmodule

`default_nettype wire

// File: verif/list_shadow_pkg.sv
// Scoreboard for the pooled linked list engine: a shadow copy of the node pool,
// head link and used count that predicts each result and checks the DUT's output.
// Depends on plle_pkg for the item, result, kind and status types.
package list_shadow_pkg;

    import plle_pkg::*;

    class list_shadow;
        // Shadow of the engine state
        val_t  vals[POOL_CAP];
        link_t links[POOL_CAP];
        link_t head;
        int    used;

        // Results owed by the DUT, oldest first
        res_t  awaited_results[$];
        int    errors;

        function new();
            head   = LINK_NONE;
            used   = 0;
            errors = 0;
        endfunction

        // A link names a node when it is non-negative and below the used count
        function bit is_live(link_t i);
            return (i >= 0) && (int'(i) < used);
        endfunction

        function void owe(val_t v, int idx, stat_t st);
            res_t r;
            r.removed_value = v;
            r.new_index     = idx[NIDX_W-1:0];
            r.status        = st;
            awaited_results.push_back(r);
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        // Apply one accepted input transfer to the shadow and queue its result, if any
        function void note_item(item_t it);
            link_t victim;
            case (it.kind)
                KIND_BEGIN: begin
                    head = it.pos;
                    used = 0;
                end
                KIND_LOAD: begin
                    if (used >= POOL_CAP) begin
                        owe('0, 0, ST_FULL);
                    end else begin
                        vals[used]  = it.payload;
                        links[used] = it.link;
                        used++;
                    end
                end
                KIND_REMOVE: begin
                    if (it.pos == LINK_NONE) begin
                        victim = head;
                        if (!is_live(victim)) begin
                            owe('0, 0, ST_NONODE);
                        end else begin
                            head = links[victim];
                            owe(vals[victim], 0, ST_OK);
                        end
                    end else if (!is_live(it.pos)) begin
                        owe('0, 0, ST_NONODE);
                    end else begin
                        victim = links[it.pos];
                        if (!is_live(victim)) begin
                            owe('0, 0, ST_NONODE);
                        end else begin
                            links[it.pos] = links[victim];
                            owe(vals[victim], 0, ST_OK);
                        end
                    end
                end
                default: begin
                    // insert: pool-full wins over a bad position
                    if (used >= POOL_CAP) begin
                        owe('0, 0, ST_FULL);
                    end else if (it.pos != LINK_NONE && !is_live(it.pos)) begin
                        owe('0, 0, ST_NONODE);
                    end else begin
                        if (it.pos == LINK_NONE) begin
                            links[used] = head;
                            head        = link_t'(used);
                        end else begin
                            links[used]   = links[it.pos];
                            links[it.pos] = link_t'(used);
                        end
                        vals[used] = it.payload;
                        owe('0, used, ST_OK);
                        used++;
                    end
                end
            endcase
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= 10)
                $display("[%0t] ERROR: %s", $time, what);
        endfunction

        // Compare one result transfer against the oldest prediction
        function void check_result(res_t got);
            res_t want;
            if (awaited_results.size() == 0) begin
                flag($sformatf("unexpected result value=%h index=%0d status=%0d",
                               got.removed_value, got.new_index, got.status));
                return;
            end
            want = awaited_results.pop_front();
            if (got.removed_value !== want.removed_value ||
                got.new_index !== want.new_index || got.status !== want.status)
                flag($sformatf({"result mismatch: exp value=%h index=%0d status=%0d",
                                " got value=%h index=%0d status=%0d"},
                               want.removed_value, want.new_index, want.status,
                               got.removed_value, got.new_index, got.status));
        endfunction

        function void close_out();
            if (awaited_results.size() != 0)
                flag($sformatf("%0d result(s) never arrived", awaited_results.size()));
        endfunction
    endclass

endpackage

// File: verif/tb_pooled_linked_list_engine.sv
// Testbench for pooled_linked_list_engine: directed list operations and random
// list-building episodes, checked by list_shadow_pkg.
// Depends on plle_pkg, list_shadow_pkg and the engine RTL.
module tb_pooled_linked_list_engine;

    timeunit 1ns;
    timeprecision 1ps;

    import plle_pkg::*;
    import list_shadow_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int STALL_CYCLES = 400;
    localparam int STALL_AFTER  = 150;
    localparam int QUIET_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 920;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;

    list_shadow shadow;
    int         items_sent;
    int         results_taken;
    bit         no_idle;
    bit         stall_done;

    pooled_linked_list_engine u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 12 ns clock
    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    function automatic val_t rnd64();
        return {$urandom, $urandom};
    endfunction

    // Mostly a live node or the head marker, sometimes any 11-bit value
    function automatic link_t pick_pos();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return link_t'($urandom_range(0, 2047));
        if (r < 30 || shadow.used == 0)
            return LINK_NONE;
        return link_t'($urandom_range(0, shadow.used - 1));
    endfunction

    // Offer one item, with random idle cycles ahead of it unless no_idle is set, and log it on transfer
    task automatic send_item(kind_t k, link_t p, val_t v, link_t l);
        int    gap;
        item_t it;
        gap = 0;
        if (!no_idle)
            while ($urandom_range(0, 99) < 33)
                gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {2'b00, l, v, p};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        it.kind    = k;
        it.pos     = p;
        it.payload = v;
        it.link    = l;
        shadow.note_item(it);
        items_sent++;
    endtask

    // Result monitor
    always @(posedge aclk) begin
        res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.removed_value = m_tdata[63:0];
            got.new_index     = m_tdata[73:64];
            got.status        = m_tuser;
            shadow.check_result(got);
            results_taken++;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("tb_pooled_linked_list_engine NOT OK");
            $finish;
        end
    end

    // Result side: random backpressure, one long hold-off to fill the engine
    initial begin
        m_tready   = 1'b0;
        stall_done = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (!stall_done && results_taken >= STALL_AFTER) begin
                stall_done = 1'b1;
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= no_idle || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    // Stimulus
    initial begin
        int    n;
        int    m;
        int    i;
        int    r;
        int    rand_start;
        kind_t op;
        link_t hd;
        link_t lk;

        shadow        = new();
        items_sent    = 0;
        results_taken = 0;
        no_idle       = 1'b0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = KIND_BEGIN;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty list, head and mid-list edits, bad positions, odd heads
        send_item(KIND_REMOVE, LINK_NONE, rnd64(), LINK_NONE);       // empty list
        send_item(KIND_INSERT, link_t'(5), rnd64(), link_t'(0));     // missing node
        send_item(KIND_INSERT, LINK_NONE, rnd64(), link_t'(1023));   // at head
        send_item(KIND_LOAD, link_t'(1023), '1, LINK_NONE);
        send_item(KIND_INSERT, link_t'(0), '0, link_t'(11'h400));
        send_item(KIND_LOAD, link_t'(0), 64'h8000_0000_0000_0000, link_t'(1));
        send_item(KIND_REMOVE, link_t'(3), rnd64(), LINK_NONE);      // after a node
        send_item(KIND_REMOVE, link_t'(1023), rnd64(), LINK_NONE);   // out of range
        send_item(KIND_REMOVE, link_t'(11'h400), rnd64(), LINK_NONE); // negative
        send_item(KIND_INSERT, link_t'(1023), rnd64(), LINK_NONE);
        send_item(KIND_INSERT, link_t'(11'h400), rnd64(), LINK_NONE);
        send_item(KIND_REMOVE, link_t'(2), rnd64(), LINK_NONE);      // tail has no next
        send_item(KIND_REMOVE, LINK_NONE, rnd64(), LINK_NONE);
        send_item(KIND_REMOVE, LINK_NONE, rnd64(), LINK_NONE);
        send_item(KIND_BEGIN, link_t'(1023), '1, link_t'(1023));     // invalid head
        send_item(KIND_REMOVE, LINK_NONE, rnd64(), LINK_NONE);
        send_item(KIND_LOAD, link_t'(0), rnd64(), link_t'(1023));
        send_item(KIND_BEGIN, link_t'(0), rnd64(), LINK_NONE);       // head past count
        send_item(KIND_REMOVE, LINK_NONE, rnd64(), LINK_NONE);
        send_item(KIND_LOAD, LINK_NONE, rnd64(), link_t'(0));        // self loop
        send_item(KIND_REMOVE, LINK_NONE, rnd64(), LINK_NONE);
        send_item(KIND_REMOVE, link_t'(0), rnd64(), LINK_NONE);
        send_item(KIND_BEGIN, LINK_NONE, '0, '0);

        // Random: mostly build-a-chain episodes, with some raw noise
        rand_start = items_sent;
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            no_idle = (items_sent - rand_start >= 300) && (items_sent - rand_start < 550);
            r = $urandom_range(0, 99);
            if (r < 8) begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                    send_item(kind_t'($urandom_range(0, 3)),
                              link_t'($urandom_range(0, 2047)), rnd64(),
                              link_t'($urandom_range(0, 2047)));
            end else begin
                n  = $urandom_range(1, 24);
                hd = ($urandom_range(0, 3) == 0) ? link_t'($urandom_range(0, 2047))
                                                 : link_t'(0);
                send_item(KIND_BEGIN, hd, rnd64(), link_t'($urandom_range(0, 2047)));
                for (i = 0; i < n; i++) begin
                    lk = (i + 1 < n) ? link_t'(i + 1) : LINK_NONE;
                    if ($urandom_range(0, 9) == 0)
                        lk = pick_pos();
                    send_item(KIND_LOAD, link_t'($urandom_range(0, 2047)), rnd64(), lk);
                end
                m = $urandom_range(4, 30);
                for (i = 0; i < m; i++) begin
                    r  = $urandom_range(0, 99);
                    op = (r < 45) ? KIND_REMOVE : (r < 90) ? KIND_INSERT : KIND_LOAD;
                    send_item(op, pick_pos(), rnd64(), pick_pos());
                end
            end
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        // Drain, then give stray results time to show up
        while (shadow.pending() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        shadow.close_out();
        if (shadow.errors == 0)
            $display("tb_pooled_linked_list_engine OK");
        else
            $display("tb_pooled_linked_list_engine NOT OK");
        $finish;
    end

endmodule
